/* hw/rtl/lfp_pkg.sv */
// ============================================================================
// lfp_pkg: shared types and constants of the Lambert forward projection
// Holds the fixed-point formats, the CORDIC arc table, the 2^(2^-k) table
// and the word types that travel along the chains of cells.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

    localparam int CORDIC_STAGES = 32;
    localparam int FRAC_BITS     = 16;
    localparam int LOG_FRAC      = 26;

    // CORDIC datapath width: magnitudes stay below 2^31 in both rotators.
    localparam int CW    = 34;
    localparam int STG_W = $clog2(CORDIC_STAGES);
    localparam int PK_W  = $clog2(LOG_FRAC + 1);
    localparam int ARC_N = 32;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 41;

    localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);

    typedef enum logic [CFG_IW-1:0] {
        REG_CONE   = 3'd0,
        REG_ALPHA  = 3'd1,
        REG_OFFX   = 3'd2,
        REG_OFFY   = 3'd3,
        REG_CENTER = 3'd4
    } cfg_reg_t;

    typedef logic [31:0] arc_tab_t [0:ARC_N-1];
    localparam arc_tab_t ARC_TAB = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    function automatic logic signed [CW-1:0] cordic_arc(input int idx);
        logic signed [CW-1:0] a;
        a = '0;
        if (idx < ARC_N) begin
            a = CW'(ARC_TAB[idx]);
        end
        return a;
    endfunction

    // Integer square root, one result bit per step.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = v;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    typedef logic [31:0] pow_tab_t [0:LOG_FRAC];

    // Entry k holds 2^(2^-k) in Q30, each obtained as the square root of the last.
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t    tab;
        logic [63:0] t;
        t      = 64'd1 << 31;
        tab[0] = t[31:0];
        for (int k = 1; k <= LOG_FRAC; k++) begin
            t      = isqrt64(t << 30);
            tab[k] = t[31:0];
        end
        return tab;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

    function automatic logic [31:0] pow_entry(input int k);
        return POW_TAB[k];
    endfunction

    typedef struct packed {
        logic flip;
        logic zero;
        logic inf;
        logic norm;
    } side_t;

    typedef struct packed {
        logic                 valid;
        side_t                side;
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic signed [CW-1:0] tz;
        logic signed [CW-1:0] ux;
        logic signed [CW-1:0] uy;
        logic signed [CW-1:0] uz;
    } cord_t;

    typedef struct packed {
        logic                 valid;
        side_t                side;
        logic signed [CW-1:0] cosv;
        logic signed [CW-1:0] sinv;
        logic [31:0]          sx;
        logic [31:0]          cx;
        logic [LOG_FRAC-1:0]  sfr;
        logic [LOG_FRAC-1:0]  cfr;
        logic [4:0]           sm;
        logic [4:0]           cm;
    } log_t;

    typedef struct packed {
        logic                 valid;
        side_t                side;
        logic signed [CW-1:0] cosv;
        logic signed [CW-1:0] sinv;
        logic [31:0]          mant;
        logic signed [7:0]    ei;
        logic [LOG_FRAC-1:0]  f;
    } pow_t;

endpackage

`default_nettype wire

/* hw/rtl/lfp_cordic_cell.sv */
// ============================================================================
// lfp_cordic_cell: one CORDIC micro-rotation for both rotators
// Rotates the trig vector and the tangent vector by one arc step and hands
// the result to the next cell.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lfp_cordic_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic [lfp_pkg::STG_W-1:0] stage,
    input  wire lfp_pkg::cord_t            din,
    output lfp_pkg::cord_t                 dout
);
    import lfp_pkg::*;

    cord_t                dout_reg;
    cord_t                dout_next;
    logic signed [CW-1:0] arc;

    always_comb begin
        arc       = cordic_arc(int'(stage));
        dout_next = din;
        if (!din.tz[CW-1]) begin
            dout_next.tx = din.tx - (din.ty >>> stage);
            dout_next.ty = din.ty + (din.tx >>> stage);
            dout_next.tz = din.tz - arc;
        end else begin
            dout_next.tx = din.tx + (din.ty >>> stage);
            dout_next.ty = din.ty - (din.tx >>> stage);
            dout_next.tz = din.tz + arc;
        end
        if (!din.uz[CW-1]) begin
            dout_next.ux = din.ux - (din.uy >>> stage);
            dout_next.uy = din.uy + (din.ux >>> stage);
            dout_next.uz = din.uz - arc;
        end else begin
            dout_next.ux = din.ux + (din.uy >>> stage);
            dout_next.uy = din.uy - (din.ux >>> stage);
            dout_next.uz = din.uz + arc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

/* hw/rtl/lfp_log_cell.sv */
// ============================================================================
// lfp_log_cell: one binary digit of log2 for both tangent operands
// Squares the normalized mantissa and shifts out one fraction bit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lfp_log_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire lfp_pkg::log_t din,
    output lfp_pkg::log_t      dout
);
    import lfp_pkg::*;

    log_t        dout_reg;
    log_t        dout_next;
    logic [63:0] sprod;
    logic [63:0] cprod;
    logic [31:0] ssq;
    logic [31:0] csq;

    always_comb begin
        sprod     = 64'(din.sx) * 64'(din.sx);
        cprod     = 64'(din.cx) * 64'(din.cx);
        ssq       = sprod[61:30];
        csq       = cprod[61:30];
        dout_next = din;
        dout_next.sx  = ssq[31] ? {1'b0, ssq[31:1]} : ssq;
        dout_next.cx  = csq[31] ? {1'b0, csq[31:1]} : csq;
        dout_next.sfr = {din.sfr[LOG_FRAC-2:0], ssq[31]};
        dout_next.cfr = {din.cfr[LOG_FRAC-2:0], csq[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

/* hw/rtl/lfp_pow_cell.sv */
// ============================================================================
// lfp_pow_cell: one fraction bit of the power 2^f
// Multiplies the mantissa by 2^(2^-k) when the leading fraction bit is set.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lfp_pow_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     adv,
    input  wire logic [lfp_pkg::PK_W-1:0] k,
    input  wire lfp_pkg::pow_t            din,
    output lfp_pkg::pow_t                 dout
);
    import lfp_pkg::*;

    pow_t        dout_reg;
    pow_t        dout_next;
    logic [63:0] mprod;

    always_comb begin
        mprod     = 64'(din.mant) * 64'(pow_entry(int'(k))) + (64'd1 << 29);
        dout_next = din;
        dout_next.mant = din.f[LOG_FRAC-1] ? mprod[61:30] : din.mant;
        dout_next.f    = din.f << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

/* hw/rtl/lambert_forward_projection.sv */
// ============================================================================
// lambert_forward_projection: Lambert conformal conic forward projection
// Maps a latitude/longitude word, given as binary angles, to saturated grid
// coordinates. The whole block is one pipeline of cells that advances as a
// unit: it takes one word per clock while the output side does not stall,
// and returns one result word per input word, in order. On its way to the
// output a word passes 94 registers (two input stages, one cell per CORDIC
// micro-rotation, one per log2 digit, one per fraction bit of the power,
// seven stages for the fold, the exponent and the scaled terms, and the
// output register). A stall on the output holds every stage, so the input
// is taken in exactly the cycles in which the output register is empty or
// being emptied.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lambert_forward_projection (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [lfp_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [lfp_pkg::CFG_DW-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [31:0]         latitude,
    input  wire logic signed [31:0]         longitude,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [39:0]              grid_x,
    output logic signed [39:0]              grid_y,
    output logic                            status
);
    import lfp_pkg::*;

    // The scaled product |alpha| * q stays below 2^77.
    localparam int PW = 77;
    localparam logic [50:0] TERM_CAP = 51'd1 << 50;
    localparam logic signed [53:0] OUT_MAX = (54'sd1 <<< 39) - 54'sd1;
    localparam logic signed [53:0] OUT_MIN = -(54'sd1 <<< 39);
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] latc;
        logic signed [32:0] d;
    } s0_t;

    typedef struct packed {
        logic               valid;
        side_t              side;
        logic signed [64:0] thp;
        logic signed [31:0] tang;
    } s1_t;

    typedef struct packed {
        logic                 valid;
        side_t                side;
        logic signed [CW-1:0] cosv;
        logic signed [CW-1:0] sinv;
        logic [31:0]          sv;
        logic [31:0]          cv;
        logic [4:0]           sm;
        logic [4:0]           cm;
    } pst_t;

    typedef struct packed {
        logic                 valid;
        side_t                side;
        logic signed [CW-1:0] cosv;
        logic signed [CW-1:0] sinv;
        logic signed [64:0]   p;
    } exp_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              inf;
        logic              negx;
        logic              negy;
        logic signed [7:0] ei;
        logic [35:0]       qx;
        logic [35:0]       qy;
    } tq_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              inf;
        logic              negx;
        logic              negy;
        logic signed [7:0] ei;
        logic [67:0]       p0x;
        logic [44:0]       p1x;
        logic [67:0]       p0y;
        logic [44:0]       p1y;
    } tp_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              inf;
        logic              negx;
        logic              negy;
        logic signed [7:0] ei;
        logic [PW-1:0]     prx;
        logic [PW-1:0]     pry;
    } tc_t;

    typedef struct packed {
        logic        valid;
        logic        zero;
        logic        inf;
        logic        negx;
        logic        negy;
        logic [50:0] magx;
        logic [50:0] magy;
    } tr_t;

    // Configuration registers.
    logic signed [31:0] cone_reg;
    logic signed [40:0] alpha_reg;
    logic signed [39:0] offx_reg;
    logic signed [39:0] offy_reg;
    logic signed [31:0] center_reg;

    // Pipeline stages.
    s0_t   s0_reg, s0_next;
    s1_t   s1_reg, s1_next;
    pst_t  ps_reg, ps_next;
    exp_t  e0_reg, e0_next;
    exp_t  e1_reg, e1_next;
    tq_t   tq_reg, tq_next;
    tp_t   tp_reg, tp_next;
    tc_t   tc_reg, tc_next;
    tr_t   tr_reg, tr_next;
    cord_t cord [0:CORDIC_STAGES];
    log_t  lgc [0:LOG_FRAC];
    pow_t  pwc [0:LOG_FRAC];

    logic               out_valid_reg, out_valid_next;
    logic signed [39:0] grid_x_reg, grid_x_next;
    logic signed [39:0] grid_y_reg, grid_y_next;
    logic               status_reg, status_next;

    logic adv;

    // The pipeline moves whenever the output register can take a word.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------------
    // Configuration writes; an index beyond the register list is ignored.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cone_reg   <= 32'sd1073741824;
            alpha_reg  <= 41'sd65536;
            offx_reg   <= '0;
            offy_reg   <= '0;
            center_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CONE:   cone_reg   <= cfg_data[31:0];
                REG_ALPHA:  alpha_reg  <= cfg_data[40:0];
                REG_OFFX:   offx_reg   <= cfg_data[39:0];
                REG_OFFY:   offy_reg   <= cfg_data[39:0];
                REG_CENTER: center_reg <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input stage: clamp latitude to the poles, form the unwrapped
    // longitude difference.
    // ------------------------------------------------------------------------
    always_comb begin
        s0_next.valid = in_valid;
        if (latitude > Q30_ONE) begin
            s0_next.latc = Q30_ONE;
        end else if (latitude < -Q30_ONE) begin
            s0_next.latc = -Q30_ONE;
        end else begin
            s0_next.latc = latitude;
        end
        s0_next.d = 33'(center_reg) - 33'(longitude);
    end

    // Second stage: cone times the longitude difference, the tangent angle
    // pi/4 - lat/2, and the pole and cone-zero special cases.
    always_comb begin
        s1_next.valid = s0_reg.valid;
        s1_next.thp   = 65'(cone_reg) * 65'(s0_reg.d);
        s1_next.tang  = 32'sd536870912 - (s0_reg.latc >>> 1);
        s1_next.side  = '0;
        if (cone_reg == '0) begin
            s1_next.side.norm = 1'b0;
        end else if (s0_reg.latc == Q30_ONE) begin
            s1_next.side.zero = !cone_reg[31];
            s1_next.side.inf  = cone_reg[31];
        end else if (s0_reg.latc == -Q30_ONE) begin
            s1_next.side.zero = cone_reg[31];
            s1_next.side.inf  = !cone_reg[31];
        end else begin
            s1_next.side.norm = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else if (adv)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------------
    // Round theta, wrap it to one turn and fold it into the right half plane;
    // a fold by half a turn negates both sine and cosine afterwards.
    // ------------------------------------------------------------------------
    logic signed [65:0]   th_sum;
    logic signed [CW-1:0] th_w;

    always_comb begin
        th_sum = 66'(s1_reg.thp) + 66'sd536870912;
        th_w   = CW'($signed(th_sum[61:30]));
        cord[0]           = '0;
        cord[0].valid     = s1_reg.valid;
        cord[0].side      = s1_reg.side;
        cord[0].side.flip = 1'b0;
        cord[0].tz        = th_w;
        if (th_w > CW'(Q30_ONE)) begin
            cord[0].tz        = th_w - (CW'(1) <<< 31);
            cord[0].side.flip = 1'b1;
        end else if (th_w < -CW'(Q30_ONE)) begin
            cord[0].tz        = th_w + (CW'(1) <<< 31);
            cord[0].side.flip = 1'b1;
        end
        cord[0].tx = GAIN_INV;
        cord[0].ux = GAIN_INV;
        cord[0].uz = CW'(s1_reg.tang);
    end

    // Chain of CORDIC cells, one micro-rotation each.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        lfp_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .stage (STG_W'(g)),
            .din   (cord[g]),
            .dout  (cord[g+1])
        );
    end

    // ------------------------------------------------------------------------
    // After the rotations: apply the fold, raise the tangent operands to at
    // least one unit and find their leading one.
    // ------------------------------------------------------------------------
    always_comb begin
        ps_next.valid = cord[CORDIC_STAGES].valid;
        ps_next.side  = cord[CORDIC_STAGES].side;
        ps_next.cosv  = cord[CORDIC_STAGES].side.flip ? -cord[CORDIC_STAGES].tx
                                                      : cord[CORDIC_STAGES].tx;
        ps_next.sinv  = cord[CORDIC_STAGES].side.flip ? -cord[CORDIC_STAGES].ty
                                                      : cord[CORDIC_STAGES].ty;
        ps_next.cv = (cord[CORDIC_STAGES].ux < CW'(1)) ? 32'd1
                                                       : cord[CORDIC_STAGES].ux[31:0];
        ps_next.sv = (cord[CORDIC_STAGES].uy < CW'(1)) ? 32'd1
                                                       : cord[CORDIC_STAGES].uy[31:0];
        ps_next.cm = '0;
        ps_next.sm = '0;
        for (int i = 0; i < 32; i++) begin
            if (ps_next.cv[i]) begin
                ps_next.cm = 5'(i);
            end
            if (ps_next.sv[i]) begin
                ps_next.sm = 5'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= '0;
        end
        else if (adv)
        begin
            ps_reg <= ps_next;
        end
    end

    // Normalize both operands to a Q30 mantissa in [1, 2).
    always_comb begin
        lgc[0]       = '0;
        lgc[0].valid = ps_reg.valid;
        lgc[0].side  = ps_reg.side;
        lgc[0].cosv  = ps_reg.cosv;
        lgc[0].sinv  = ps_reg.sinv;
        lgc[0].sm    = ps_reg.sm;
        lgc[0].cm    = ps_reg.cm;
        lgc[0].sx    = (ps_reg.sm >= 5'd30) ? (ps_reg.sv >> (ps_reg.sm - 5'd30))
                                            : (ps_reg.sv << (5'd30 - ps_reg.sm));
        lgc[0].cx    = (ps_reg.cm >= 5'd30) ? (ps_reg.cv >> (ps_reg.cm - 5'd30))
                                            : (ps_reg.cv << (5'd30 - ps_reg.cm));
    end

    // Chain of log2 cells, one fraction digit each.
    for (genvar g = 0; g < LOG_FRAC; g++) begin : g_log
        lfp_log_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (lgc[g]),
            .dout  (lgc[g+1])
        );
    end

    // ------------------------------------------------------------------------
    // Exponent: log2(tan) as log2(sin) - log2(cos), then times the cone.
    // ------------------------------------------------------------------------
    always_comb begin
        e0_next.valid = lgc[LOG_FRAC].valid;
        e0_next.side  = lgc[LOG_FRAC].side;
        e0_next.cosv  = lgc[LOG_FRAC].cosv;
        e0_next.sinv  = lgc[LOG_FRAC].sinv;
        e0_next.p     = 65'($signed({2'b00, lgc[LOG_FRAC].sm, lgc[LOG_FRAC].sfr})
                      - $signed({2'b00, lgc[LOG_FRAC].cm, lgc[LOG_FRAC].cfr}));
        e1_next       = e0_reg;
        e1_next.p     = 65'(cone_reg) * e0_reg.p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_reg <= '0;
            e1_reg <= '0;
        end
        else if (adv)
        begin
            e0_reg <= e0_next;
            e1_reg <= e1_next;
        end
    end

    // Split the rounded exponent into its integer part and fraction. Outside
    // the ordinary case the radius is one: no fraction, no shift.
    logic signed [65:0] e_sum;

    always_comb begin
        e_sum        = 66'(e1_reg.p) + 66'sd536870912;
        pwc[0]       = '0;
        pwc[0].valid = e1_reg.valid;
        pwc[0].side  = e1_reg.side;
        pwc[0].cosv  = e1_reg.cosv;
        pwc[0].sinv  = e1_reg.sinv;
        pwc[0].mant  = 32'd1 << 30;
        if (e1_reg.side.norm) begin
            pwc[0].ei = e_sum[63:56];
            pwc[0].f  = e_sum[55:30];
        end
    end

    // Chain of power cells, one fraction bit each.
    for (genvar g = 0; g < LOG_FRAC; g++) begin : g_pow
        lfp_pow_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .k     (PK_W'(g + 1)),
            .din   (pwc[g]),
            .dout  (pwc[g+1])
        );
    end

    // ------------------------------------------------------------------------
    // Scaled terms alpha * r * sin(theta) and -alpha * r * cos(theta).
    // ------------------------------------------------------------------------
    logic [CW-1:0] mtx;
    logic [CW-1:0] mty;
    logic [65:0]   qpx;
    logic [65:0]   qpy;
    logic [40:0]   aabs;

    assign aabs = alpha_reg[40] ? 41'(-alpha_reg) : 41'(alpha_reg);

    always_comb begin
        mtx = pwc[LOG_FRAC].sinv[CW-1] ? CW'(-pwc[LOG_FRAC].sinv) : CW'(pwc[LOG_FRAC].sinv);
        mty = pwc[LOG_FRAC].cosv[CW-1] ? CW'(-pwc[LOG_FRAC].cosv) : CW'(pwc[LOG_FRAC].cosv);
        qpx = 66'(pwc[LOG_FRAC].mant) * 66'(mtx) + (66'd1 << 29);
        qpy = 66'(pwc[LOG_FRAC].mant) * 66'(mty) + (66'd1 << 29);
        tq_next.valid = pwc[LOG_FRAC].valid;
        tq_next.zero  = pwc[LOG_FRAC].side.zero;
        tq_next.inf   = pwc[LOG_FRAC].side.inf;
        tq_next.ei    = pwc[LOG_FRAC].ei;
        tq_next.qx    = qpx[65:30];
        tq_next.qy    = qpy[65:30];
        // The y term uses -cos, so it is negative when cos is positive.
        tq_next.negx  = alpha_reg[40] ^ pwc[LOG_FRAC].sinv[CW-1];
        tq_next.negy  = alpha_reg[40] ^ (pwc[LOG_FRAC].cosv > CW'(0));

        // |alpha| is 41 bits wide, so the product goes as two partial products.
        tp_next.valid = tq_reg.valid;
        tp_next.zero  = tq_reg.zero;
        tp_next.inf   = tq_reg.inf;
        tp_next.negx  = tq_reg.negx;
        tp_next.negy  = tq_reg.negy;
        tp_next.ei    = tq_reg.ei;
        tp_next.p0x   = 68'(aabs[31:0]) * 68'(tq_reg.qx);
        tp_next.p1x   = 45'(aabs[40:32]) * 45'(tq_reg.qx);
        tp_next.p0y   = 68'(aabs[31:0]) * 68'(tq_reg.qy);
        tp_next.p1y   = 45'(aabs[40:32]) * 45'(tq_reg.qy);

        tc_next.valid = tp_reg.valid;
        tc_next.zero  = tp_reg.zero;
        tc_next.inf   = tp_reg.inf;
        tc_next.negx  = tp_reg.negx;
        tc_next.negy  = tp_reg.negy;
        tc_next.ei    = tp_reg.ei;
        tc_next.prx   = PW'(tp_reg.p0x) + (PW'(tp_reg.p1x) << 32);
        tc_next.pry   = PW'(tp_reg.p0y) + (PW'(tp_reg.p1y) << 32);
    end

    // Magnitude of one term: the product shifted by ei - 30 with rounding
    // half away from zero, capped at 2^50. An infinite radius caps any term
    // whose product is not zero.
    function automatic logic [50:0] term_mag(input logic [PW-1:0] prod,
                                             input logic signed [7:0] ei,
                                             input logic inf);
        logic signed [8:0] sh;
        logic [5:0]        su;
        logic [6:0]        n;
        logic [PW:0]       rs;
        logic [50:0]       mag;
        sh  = 9'(ei) - 9'sd30;
        su  = sh[5:0];
        n   = 7'(-sh);
        rs  = '0;
        mag = '0;
        if (prod == '0) begin
            mag = '0;
        end else if (inf) begin
            mag = TERM_CAP;
        end else if (!sh[8]) begin
            if (sh > 9'sd49 || (prod >> (6'd50 - su)) != '0) begin
                mag = TERM_CAP;
            end else begin
                mag = 51'(prod << su);
            end
        end else if (n > 7'(PW)) begin
            mag = '0;
        end else begin
            rs  = ({1'b0, prod} + ((PW+1)'(1) << (n - 7'd1))) >> n;
            mag = (rs > (PW+1)'(TERM_CAP)) ? TERM_CAP : rs[50:0];
        end
        return mag;
    endfunction

    always_comb begin
        tr_next.valid = tc_reg.valid;
        tr_next.zero  = tc_reg.zero;
        tr_next.inf   = tc_reg.inf;
        tr_next.negx  = tc_reg.negx;
        tr_next.negy  = tc_reg.negy;
        tr_next.magx  = term_mag(tc_reg.prx, tc_reg.ei, tc_reg.inf);
        tr_next.magy  = term_mag(tc_reg.pry, tc_reg.ei, tc_reg.inf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tq_reg <= '0;
            tp_reg <= '0;
            tc_reg <= '0;
            tr_reg <= '0;
        end
        else if (adv)
        begin
            tq_reg <= tq_next;
            tp_reg <= tp_next;
            tc_reg <= tc_next;
            tr_reg <= tr_next;
        end
    end

    // ------------------------------------------------------------------------
    // Output stage: add the offsets and clamp to 40 bits. At the pole where
    // the radius is zero the offsets pass unchanged.
    // ------------------------------------------------------------------------
    logic signed [53:0] sum_x;
    logic signed [53:0] sum_y;
    logic               sat_x;
    logic               sat_y;

    always_comb begin
        sum_x = 54'(offx_reg) + (tr_reg.negx ? -$signed({3'b000, tr_reg.magx})
                                             : $signed({3'b000, tr_reg.magx}));
        sum_y = 54'(offy_reg) + (tr_reg.negy ? -$signed({3'b000, tr_reg.magy})
                                             : $signed({3'b000, tr_reg.magy}));
        sat_x = (sum_x > OUT_MAX) || (sum_x < OUT_MIN);
        sat_y = (sum_y > OUT_MAX) || (sum_y < OUT_MIN);
        out_valid_next = tr_reg.valid;
        if (tr_reg.zero) begin
            grid_x_next = offx_reg;
            grid_y_next = offy_reg;
            status_next = 1'b0;
        end else begin
            grid_x_next = (sum_x > OUT_MAX) ? OUT_MAX[39:0]
                        : (sum_x < OUT_MIN) ? OUT_MIN[39:0] : sum_x[39:0];
            grid_y_next = (sum_y > OUT_MAX) ? OUT_MAX[39:0]
                        : (sum_y < OUT_MIN) ? OUT_MIN[39:0] : sum_y[39:0];
            status_next = tr_reg.inf || sat_x || sat_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            grid_x_reg <= grid_x_next;
            grid_y_reg <= grid_y_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign grid_x    = grid_x_reg;
    assign grid_y    = grid_y_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

/* hw/rtl/lfp_checker.sv */
// ============================================================================
// lfp_checker: port-level checks of the Lambert forward projection
// Watches the handshakes of the top level and is bound to it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lfp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic signed [31:0] latitude,
    input wire logic signed [31:0] longitude,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [39:0] grid_x,
    input wire logic signed [39:0] grid_y,
    input wire logic               status
);

    // A waiting input word stays on the port unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(latitude) && $stable(longitude))
        else $error("input word changed while waiting");

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(grid_x) && $stable(grid_y)
                                    && $stable(status))
        else $error("result word changed while stalled");

    // The pipeline takes a word exactly when its output register can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow the output side");

    // A new result can only appear once the pipeline has moved.
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared without the pipeline advancing");

endmodule

bind lambert_forward_projection lfp_checker u_lfp_checker (.*);

`default_nettype wire
